[src/ppnm_pkg.sv]
// shared types, character codes and result codes for the plain netpbm decoder
package ppnm_pkg;

    localparam int DEF_MAX_DIM    = 4096;
    localparam int DEF_MAX_SAMPLE = 65535;

    localparam int TOKEN_W          = 17;
    localparam logic [TOKEN_W-1:0] TOKEN_CAP = 17'h1FFFF;
    localparam int QUO_W            = 8;
    localparam int DIV_STEPS        = QUO_W;
    localparam int DIV_CNT_W        = $clog2(DIV_STEPS);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_P     = 8'h50;

    localparam logic [7:0] SAMPLE_FULL = 8'd255;

    localparam logic [1:0] FMT_NONE = 2'd0;
    localparam logic [1:0] FMT_PBM  = 2'd1;
    localparam logic [1:0] FMT_PPM  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_BAD_CHAR  = 3'd2;
    localparam logic [2:0] ST_BAD_VALUE = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;

    typedef enum logic [2:0] {
        PH_MAGIC0,
        PH_MAGIC1,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXVAL,
        PH_PIXELS,
        PH_DONE,
        PH_FAULT
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TAIL,
        S_DIV,
        S_PUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        OP_MOVE,
        OP_BYTE,
        OP_FLUSH,
        OP_DIV,
        OP_PUT,
        OP_FINAL
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic pend_valid;
        logic div_start;
        logic div_last;
        logic flush_need;
    } dp_stat_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] status;
        logic       last_pixel;
    } out_item_t;

endpackage

[src/plain_pnm_pixel_decoder_unit.sv]
// top level of the plain netpbm pixel decoder
//
//  channel  | ports                         | moves
//  ---------+-------------------------------+-------------------------------
//  input    | s_valid s_ready s_payload     | one file byte and end flag
//  result   | m_valid m_ready m_payload     | one rgb pixel or status code
//
// a byte is taken in the idle state and closed in the tail state; a result
// waits in the pending register and moves to the output register when that is free;
// a last byte that ends an open token also needs a flush, and a sample token passes
// through the eight-step restoring divider that forms v*255/maxval, then pixel assembly
// reset is synchronous, no clearing pass
// a result in the output register blocks input only once a second is pending behind it
module plain_pnm_pixel_decoder_unit
    import ppnm_pkg::*;
#(
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int MAX_SAMPLE = DEF_MAX_SAMPLE
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ppnm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ppnm_dpath #(
        .MAX_DIM    (MAX_DIM),
        .MAX_SAMPLE (MAX_SAMPLE)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_payload (s_payload),
        .m_ready   (m_ready),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_payload (m_payload)
    );

    // error and truncation results always close the image
    a_err_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.status != ST_OK) |-> m_payload.last_pixel)
        else $error("error result without last_pixel");

    // error results carry zero samples
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.status != ST_OK) |->
        (m_payload.red == 8'd0) && (m_payload.green == 8'd0) && (m_payload.blue == 8'd0))
        else $error("error result with nonzero samples");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.status <= ST_TRUNC))
        else $error("status code out of range");

    // after an accepted byte the block leaves the idle state and drops s_ready
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("transaction accepted back to back");

    // no transaction is taken while a result is still pending behind the output
    a_no_accept_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.pend_valid |-> !s_ready)
        else $error("transaction accepted with pending result");

endmodule

[src/ppnm_ctrl.sv]
// sequencing state machine: byte, optional divide and flush, end of transaction
module ppnm_ctrl
    import ppnm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && !stat.pend_valid) begin
                    state_next = stat.div_start ? S_DIV : S_TAIL;
                end
            end
            S_TAIL: begin
                if (stat.flush_need) begin
                    state_next = stat.div_start ? S_DIV : S_TAIL;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DIV: begin
                if (stat.div_last) begin
                    state_next = S_PUT;
                end
            end
            S_PUT: begin
                state_next = S_TAIL;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd.op  = OP_MOVE;
        case (state_reg)
            S_IDLE: begin
                s_ready = !stat.pend_valid;
                cmd.op  = (s_valid && !stat.pend_valid) ? OP_BYTE : OP_MOVE;
            end
            S_TAIL: begin
                cmd.op = stat.flush_need ? OP_FLUSH : OP_FINAL;
            end
            S_DIV: begin
                cmd.op = OP_DIV;
            end
            S_PUT: begin
                cmd.op = OP_PUT;
            end
            default: begin
                cmd.op = OP_MOVE;
            end
        endcase
    end

endmodule

[src/ppnm_dpath.sv]
// parser state, token accumulator, sample divider, pending and output result registers
module ppnm_dpath
    import ppnm_pkg::*;
#(
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int MAX_SAMPLE = DEF_MAX_SAMPLE
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  dp_cmd_t   cmd,
    input  in_item_t  s_payload,
    input  logic      m_ready,
    output dp_stat_t  stat,
    output logic      m_valid,
    output out_item_t m_payload
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int PW = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int SW = $clog2(MAX_SAMPLE + 1);

    // parse state
    phase_t              phase_reg, phase_next;
    logic [1:0]          fmt_reg, fmt_next;
    logic                in_comment_reg, in_comment_next;
    logic [TOKEN_W-1:0]  token_reg, token_next;
    logic                token_active_reg, token_active_next;
    logic [DW-1:0]       width_reg, width_next;
    logic [SW-1:0]       max_sample_reg, max_sample_next;
    logic [PW-1:0]       pixels_left_reg, pixels_left_next;
    logic [1:0]          chan_reg, chan_next;
    logic [7:0]          held_red_reg, held_red_next;
    logic [7:0]          held_green_reg, held_green_next;
    logic                last_reg, last_next;

    // divider
    logic [SW-1:0]        rem_reg, rem_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    // results
    logic       pend_valid_reg, pend_valid_next;
    out_item_t  pend_reg, pend_next;
    logic       m_valid_reg, m_valid_next;
    out_item_t  out_reg, out_next;

    // working signals
    logic [7:0]         b;
    logic               is_digit, is_ws;
    logic               tok_fin, smp_fire, flt, div_start;
    logic [7:0]         smp_val;
    logic [2:0]         flt_code;
    logic [20:0]        tok_ext, tok_sum;
    logic [2*DW-1:0]    area;
    logic [SW-1:0]      tok_s;
    logic [SW+7:0]      scaled;
    logic [SW:0]        trial;
    logic               quo_bit;
    logic [PW-1:0]      left_dec;
    logic               out_free;

    assign b        = s_payload.data_byte;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_ws    = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    assign tok_ext  = 21'(token_reg);
    assign tok_sum  = (tok_ext << 3) + (tok_ext << 1) + 21'(b[3:0]);
    assign area     = width_reg * DW'(token_reg);
    assign tok_s    = SW'(token_reg);
    // v * 255 as a shift and a subtract
    assign scaled   = {tok_s, 8'd0} - (SW+8)'(tok_s);
    assign trial    = {rem_reg, quo_reg[QUO_W-1]};
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        phase_next        = phase_reg;
        fmt_next          = fmt_reg;
        in_comment_next   = in_comment_reg;
        token_next        = token_reg;
        token_active_next = token_active_reg;
        width_next        = width_reg;
        max_sample_next   = max_sample_reg;
        pixels_left_next  = pixels_left_reg;
        chan_next         = chan_reg;
        held_red_next     = held_red_reg;
        held_green_next   = held_green_reg;
        last_next         = last_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        div_cnt_next      = div_cnt_reg;
        pend_valid_next   = pend_valid_reg;
        pend_next         = pend_reg;
        m_valid_next      = m_valid_reg;
        out_next          = out_reg;
        tok_fin           = 1'b0;
        smp_fire          = 1'b0;
        smp_val           = 8'd0;
        flt               = 1'b0;
        flt_code          = ST_OK;
        div_start         = 1'b0;
        quo_bit           = 1'b0;
        left_dec          = pixels_left_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (cmd.op)
            OP_MOVE: begin
                if (pend_valid_reg && out_free) begin
                    out_next        = pend_reg;
                    m_valid_next    = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            OP_BYTE: begin
                last_next       = s_payload.last_byte;
                pend_valid_next = 1'b0;
                case (phase_reg)
                    PH_MAGIC0: begin
                        if (b == CH_P) begin
                            phase_next = PH_MAGIC1;
                        end else begin
                            flt      = 1'b1;
                            flt_code = ST_BAD_MAGIC;
                        end
                    end
                    PH_MAGIC1: begin
                        if ((b >= CH_ONE) && (b <= CH_THREE)) begin
                            fmt_next   = 2'(b - CH_ZERO);
                            phase_next = PH_WIDTH;
                        end else begin
                            flt      = 1'b1;
                            flt_code = ST_BAD_MAGIC;
                        end
                    end
                    PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIXELS: begin
                        if (in_comment_reg) begin
                            if ((b == CH_LF) || (b == CH_CR)) begin
                                in_comment_next = 1'b0;
                            end
                        end else if (is_digit) begin
                            if ((phase_reg == PH_PIXELS) && (fmt_reg == FMT_PBM)) begin
                                if (b > CH_ONE) begin
                                    flt      = 1'b1;
                                    flt_code = ST_BAD_VALUE;
                                end else begin
                                    smp_fire = 1'b1;
                                    smp_val  = (b == CH_ONE) ? SAMPLE_FULL : 8'd0;
                                end
                            end else begin
                                token_next        = (tok_sum > 21'(TOKEN_CAP)) ? TOKEN_CAP
                                                                               : TOKEN_W'(tok_sum);
                                token_active_next = 1'b1;
                            end
                        end else if (is_ws) begin
                            tok_fin = 1'b1;
                        end else if (b == CH_HASH) begin
                            tok_fin         = 1'b1;
                            in_comment_next = 1'b1;
                        end else begin
                            flt      = 1'b1;
                            flt_code = ST_BAD_CHAR;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_FLUSH: begin
                tok_fin = 1'b1;
            end
            OP_DIV: begin
                // restoring step: one quotient bit shifted in at the bottom
                if (trial >= {1'b0, max_sample_reg}) begin
                    quo_bit  = 1'b1;
                    rem_next = SW'(trial - {1'b0, max_sample_reg});
                end else begin
                    rem_next = SW'(trial);
                end
                quo_next     = {quo_reg[QUO_W-2:0], quo_bit};
                div_cnt_next = div_cnt_reg + 1'b1;
            end
            OP_PUT: begin
                smp_fire = 1'b1;
                smp_val  = quo_reg;
            end
            OP_FINAL: begin
                if (last_reg) begin
                    if ((phase_reg != PH_DONE) && (phase_reg != PH_FAULT)) begin
                        pend_valid_next      = 1'b1;
                        pend_next.red        = 8'd0;
                        pend_next.green      = 8'd0;
                        pend_next.blue       = 8'd0;
                        pend_next.status     = ST_TRUNC;
                        pend_next.last_pixel = 1'b1;
                    end
                    // rearm for the next file
                    phase_next        = PH_MAGIC0;
                    fmt_next          = FMT_NONE;
                    in_comment_next   = 1'b0;
                    token_next        = '0;
                    token_active_next = 1'b0;
                    width_next        = '0;
                    max_sample_next   = '0;
                    pixels_left_next  = '0;
                    chan_next         = 2'd0;
                    held_red_next     = 8'd0;
                    held_green_next   = 8'd0;
                    last_next         = 1'b0;
                end
            end
            default: begin
            end
        endcase

        // token completion
        if (tok_fin && token_active_reg) begin
            token_active_next = 1'b0;
            token_next        = '0;
            case (phase_reg)
                PH_WIDTH: begin
                    if ((token_reg == '0) || (token_reg > TOKEN_W'(MAX_DIM))) begin
                        flt      = 1'b1;
                        flt_code = ST_BAD_VALUE;
                    end else begin
                        width_next = DW'(token_reg);
                        phase_next = PH_HEIGHT;
                    end
                end
                PH_HEIGHT: begin
                    if ((token_reg == '0) || (token_reg > TOKEN_W'(MAX_DIM))) begin
                        flt      = 1'b1;
                        flt_code = ST_BAD_VALUE;
                    end else begin
                        pixels_left_next = PW'(area);
                        phase_next       = (fmt_reg == FMT_PBM) ? PH_PIXELS : PH_MAXVAL;
                    end
                end
                PH_MAXVAL: begin
                    if ((token_reg == '0) || (token_reg > TOKEN_W'(MAX_SAMPLE))) begin
                        flt      = 1'b1;
                        flt_code = ST_BAD_VALUE;
                    end else begin
                        max_sample_next = SW'(token_reg);
                        phase_next      = PH_PIXELS;
                    end
                end
                PH_PIXELS: begin
                    if ((token_reg > TOKEN_W'(max_sample_reg)) || (max_sample_reg == '0)) begin
                        flt      = 1'b1;
                        flt_code = ST_BAD_VALUE;
                    end else begin
                        // quotient fits in eight bits, so the top of v*255 is below maxval
                        div_start    = 1'b1;
                        rem_next     = scaled[SW+7:8];
                        quo_next     = scaled[7:0];
                        div_cnt_next = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        // sample to pixel assembly
        if (smp_fire) begin
            if (pixels_left_reg != '0) begin
                left_dec = pixels_left_reg - 1'b1;
            end
            if ((fmt_reg == FMT_PPM) && (chan_reg == 2'd0)) begin
                held_red_next = smp_val;
                chan_next     = 2'd1;
            end else if ((fmt_reg == FMT_PPM) && (chan_reg == 2'd1)) begin
                held_green_next = smp_val;
                chan_next       = 2'd2;
            end else begin
                chan_next            = 2'd0;
                pixels_left_next     = left_dec;
                pend_valid_next      = 1'b1;
                pend_next.red        = (fmt_reg == FMT_PPM) ? held_red_reg : smp_val;
                pend_next.green      = (fmt_reg == FMT_PPM) ? held_green_reg : smp_val;
                pend_next.blue       = smp_val;
                pend_next.status     = ST_OK;
                pend_next.last_pixel = (left_dec == '0);
                if (left_dec == '0) begin
                    phase_next = PH_DONE;
                end
            end
        end

        if (flt) begin
            pend_valid_next      = 1'b1;
            pend_next.red        = 8'd0;
            pend_next.green      = 8'd0;
            pend_next.blue       = 8'd0;
            pend_next.status     = flt_code;
            pend_next.last_pixel = 1'b1;
            phase_next           = PH_FAULT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_MAGIC0;
            fmt_reg          <= FMT_NONE;
            in_comment_reg   <= 1'b0;
            token_reg        <= '0;
            token_active_reg <= 1'b0;
            width_reg        <= '0;
            max_sample_reg   <= '0;
            pixels_left_reg  <= '0;
            chan_reg         <= 2'd0;
            held_red_reg     <= 8'd0;
            held_green_reg   <= 8'd0;
            last_reg         <= 1'b0;
            div_cnt_reg      <= '0;
            pend_valid_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            fmt_reg          <= fmt_next;
            in_comment_reg   <= in_comment_next;
            token_reg        <= token_next;
            token_active_reg <= token_active_next;
            width_reg        <= width_next;
            max_sample_reg   <= max_sample_next;
            pixels_left_reg  <= pixels_left_next;
            chan_reg         <= chan_next;
            held_red_reg     <= held_red_next;
            held_green_reg   <= held_green_next;
            last_reg         <= last_next;
            div_cnt_reg      <= div_cnt_next;
            pend_valid_reg   <= pend_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign stat.pend_valid = pend_valid_reg;
    assign stat.div_start  = div_start;
    assign stat.div_last   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign stat.flush_need = last_reg && !pend_valid_reg && token_active_reg &&
                             (phase_reg >= PH_WIDTH) && (phase_reg <= PH_PIXELS);

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule
